[sv/interpolation_level_search_core_assert.svh]
// ------------------------------------------------------------------------
// interpolation level search assertion macros
// concurrent checks used by the core rtl file of the block
// ------------------------------------------------------------------------
`ifndef INTERPOLATION_LEVEL_SEARCH_CORE_ASSERT_SVH
`define INTERPOLATION_LEVEL_SEARCH_CORE_ASSERT_SVH

// same-cycle implication
`define ILS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ILS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/ils_pkg.sv]
// ------------------------------------------------------------------------
// ils_pkg
// shared constants and types of the interpolation level search core
// ------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

  localparam int CODE_BITS_DEF   = 6;
  localparam int SAMPLE_BITS_DEF = 10;

  localparam int TARGET_RESET = 286;
  localparam int TOL_RESET    = 2;

  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TOL    = 1'b1;

  localparam logic REQ_START  = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [1:0] ST_SEARCH  = 2'd0;
  localparam logic [1:0] ST_FOUND   = 2'd1;
  localparam logic [1:0] ST_IDLE    = 2'd2;
  localparam logic [1:0] ST_RESTART = 2'd3;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_LOW     = 5'b00010,
    PH_HIGH    = 5'b00100,
    PH_PROBE   = 5'b01000,
    PH_MONITOR = 5'b10000
  } phase_t;

  typedef enum logic [3:0] {
    SEQ_IDLE = 4'b0001,
    SEQ_MUL  = 4'b0010,
    SEQ_DIV  = 4'b0100,
    SEQ_DONE = 4'b1000
  } seq_t;

endpackage

`default_nettype wire

[sv/interpolation_level_search_core.sv]
// a start request or a sample outside the upper-bound phase gives its registered word
//   on m_tdata in the cycle after acceptance
// the upper-bound sample runs multiply, divide and done steps, set by the serial divider
//   that forms the interpolated probe; divide is skipped when no division is needed
// throughput: one word in flight; s_tready returns once idle with the output register free
// reset: rst synchronous, active high; target 286, tolerance 2, search idle
// ------------------------------------------------------------------------
// interpolation_level_search_core
// attenuator code search by interpolation with a serial divider
// ------------------------------------------------------------------------
`default_nettype none

`include "interpolation_level_search_core_assert.svh"

module interpolation_level_search_core
  import ils_pkg::*;
#(
  parameter int CODE_BITS   = CODE_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * CODE_BITS + 7) / 8) * 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_tvalid,
  output logic                           s_tready,
  input  wire logic [IN_W-1:0]           s_tdata,  // sample_value
  input  wire logic [0:0]                s_tuser,  // req_type
  output logic                           m_tvalid,
  input  wire logic                      m_tready,
  output logic      [OUT_W-1:0]          m_tdata,  // apply_code, found_code
  output logic      [1:0]                m_tuser,  // search_status
  input  wire logic                      cfg_we,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [SAMPLE_BITS-1:0]    cfg_data
);

  localparam int PROD_W = SAMPLE_BITS + CODE_BITS;

  logic [SAMPLE_BITS-1:0] target_level;
  logic [SAMPLE_BITS-1:0] match_tolerance;

  phase_t                 phase, phase_next;
  seq_t                   seq, seq_next;
  logic [CODE_BITS-1:0]   lower_bound, lower_next;
  logic [CODE_BITS-1:0]   upper_bound, upper_next;
  logic [CODE_BITS-1:0]   probe_code, probe_next;
  logic [SAMPLE_BITS-1:0] lower_sample, lower_sample_next;
  logic [SAMPLE_BITS-1:0] upper_sample, upper_sample_next;
  logic [SAMPLE_BITS-1:0] reference_sample, reference_next;

  logic [CODE_BITS-1:0]   out_code, out_found;
  logic [1:0]             out_status;

  logic                   load;
  logic [CODE_BITS-1:0]   ld_code, ld_found;
  logic [1:0]             ld_status;
  logic                   fail;

  logic                   accept;
  logic                   out_free;
  logic                   req;
  logic [SAMPLE_BITS-1:0] sample;
  logic [SAMPLE_BITS-1:0] diff_tgt, diff_ref;
  logic                   in_hit, mon_hold;

  logic [SAMPLE_BITS-1:0] a_mag, b_mag;
  logic [CODE_BITS-1:0]   span;
  logic                   trivial;
  logic [PROD_W-1:0]      product;
  logic                   div_start, div_done;
  logic [PROD_W-1:0]      quotient;
  logic [CODE_BITS-1:0]   q_clamp;

  assign req      = s_tuser[0];
  assign sample   = s_tdata[SAMPLE_BITS-1:0];
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (seq == SEQ_IDLE) && out_free;
  assign accept   = s_tvalid && s_tready;

  assign m_tdata = OUT_W'({out_found, out_code});
  assign m_tuser = out_status;

  assign diff_tgt = (sample > target_level) ? sample - target_level : target_level - sample;
  assign diff_ref = (sample > reference_sample) ? sample - reference_sample
                                                : reference_sample - sample;
  assign in_hit   = diff_tgt <= match_tolerance;
  assign mon_hold = {1'b0, diff_ref} <= {match_tolerance, 1'b0};

  // interpolation operands, negative quotients clamp to the lower bound
  assign a_mag = (target_level > lower_sample) ? target_level - lower_sample
                                               : lower_sample - target_level;
  assign b_mag = (upper_sample > lower_sample) ? upper_sample - lower_sample
                                               : lower_sample - upper_sample;
  assign span    = upper_bound - lower_bound;
  assign trivial = (b_mag == '0) || (span == '0) || (a_mag == '0) ||
                   ((target_level < lower_sample) != (upper_sample < lower_sample));
  assign product = PROD_W'(a_mag) * PROD_W'(span);
  assign q_clamp = (quotient > PROD_W'(span)) ? span : quotient[CODE_BITS-1:0];

  ils_div #(
    .DVD_BITS (PROD_W),
    .DVS_BITS (SAMPLE_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (product),
    .divisor  (b_mag),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    phase_next        = phase;
    seq_next          = seq;
    lower_next        = lower_bound;
    upper_next        = upper_bound;
    probe_next        = probe_code;
    lower_sample_next = lower_sample;
    upper_sample_next = upper_sample;
    reference_next    = reference_sample;
    load              = 1'b0;
    ld_code           = '0;
    ld_status         = ST_IDLE;
    ld_found          = '0;
    div_start         = 1'b0;
    fail              = 1'b0;
    unique case (seq)
      SEQ_IDLE: begin
        if (accept) begin
          if (req == REQ_START) begin
            lower_next = '0;
            upper_next = '1;
            phase_next = PH_LOW;
            load       = 1'b1;
            ld_status  = ST_SEARCH;
          end else begin
            unique case (phase)
              PH_LOW: begin
                lower_sample_next = sample;
                phase_next        = PH_HIGH;
                load              = 1'b1;
                ld_code           = upper_bound;
                ld_status         = ST_SEARCH;
              end
              PH_HIGH: begin
                upper_sample_next = sample;
                seq_next          = SEQ_MUL;
              end
              PH_PROBE: begin
                if (in_hit) begin
                  reference_next = sample;
                  phase_next     = PH_MONITOR;
                  load           = 1'b1;
                  ld_code        = probe_code;
                  ld_status      = ST_FOUND;
                  ld_found       = probe_code;
                end else begin
                  if (sample < target_level) begin
                    if (probe_code == '1) fail = 1'b1;
                    else lower_next = probe_code + 1'b1;
                  end else begin
                    if (probe_code == '0) fail = 1'b1;
                    else upper_next = probe_code - 1'b1;
                  end
                  load = 1'b1;
                  if (fail || (lower_next >= upper_next)) begin
                    phase_next = PH_IDLE;
                  end else begin
                    phase_next = PH_LOW;
                    ld_code    = lower_next;
                    ld_status  = ST_SEARCH;
                  end
                end
              end
              PH_MONITOR: begin
                load = 1'b1;
                if (mon_hold) begin
                  ld_code   = probe_code;
                  ld_status = ST_FOUND;
                  ld_found  = probe_code;
                end else begin
                  reference_next = sample;
                  lower_next     = '0;
                  upper_next     = '1;
                  phase_next     = PH_LOW;
                  ld_status      = ST_RESTART;
                end
              end
              default: begin
                phase_next = PH_IDLE;
                load       = 1'b1;
              end
            endcase
          end
        end
      end
      SEQ_MUL: begin
        if (trivial) begin
          probe_next = lower_bound;
          seq_next   = SEQ_DONE;
        end else begin
          div_start = 1'b1;
          seq_next  = SEQ_DIV;
        end
      end
      SEQ_DIV: begin
        if (div_done) begin
          probe_next = lower_bound + q_clamp;
          seq_next   = SEQ_DONE;
        end
      end
      SEQ_DONE: begin
        if (out_free) begin
          phase_next = PH_PROBE;
          seq_next   = SEQ_IDLE;
          load       = 1'b1;
          ld_code    = probe_code;
          ld_status  = ST_SEARCH;
        end
      end
      default: begin
        seq_next = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_level     <= SAMPLE_BITS'(TARGET_RESET);
      match_tolerance  <= SAMPLE_BITS'(TOL_RESET);
      phase            <= PH_IDLE;
      seq              <= SEQ_IDLE;
      lower_bound      <= '0;
      upper_bound      <= '1;
      probe_code       <= '0;
      lower_sample     <= '0;
      upper_sample     <= '0;
      reference_sample <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TARGET: target_level    <= cfg_data;
          REG_TOL:    match_tolerance <= cfg_data;
          default:    ;
        endcase
      end
      phase            <= phase_next;
      seq              <= seq_next;
      lower_bound      <= lower_next;
      upper_bound      <= upper_next;
      probe_code       <= probe_next;
      lower_sample     <= lower_sample_next;
      upper_sample     <= upper_sample_next;
      reference_sample <= reference_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_code   <= ld_code;
      out_status <= ld_status;
      out_found  <= ld_found;
    end
  end

  `ILS_ASSERT_NXT(a_mul_next, clk, rst, seq == SEQ_MUL, seq == SEQ_DIV || seq == SEQ_DONE, "multiply step not followed by divide or done")
  `ILS_ASSERT_IMP(a_div_done, clk, rst, div_done, seq == SEQ_DIV, "divider finished outside the divide step")
  `ILS_ASSERT_IMP(a_probe_range, clk, rst, seq == SEQ_DONE, probe_code >= lower_bound && probe_code <= upper_bound, "probe outside the bounds")
  `ILS_ASSERT_IMP(a_found_code, clk, rst, m_tvalid && m_tuser == ST_FOUND, m_tdata[CODE_BITS-1:0] == m_tdata[2*CODE_BITS-1:CODE_BITS], "found code differs from applied code")

endmodule

`default_nettype wire

[sv/ils_div.sv]
// ------------------------------------------------------------------------
// ils_div
// restoring divider, one quotient bit per cycle, unsigned operands
// ------------------------------------------------------------------------
`default_nettype none

module ils_div
  import ils_pkg::*;
#(
  parameter int DVD_BITS = SAMPLE_BITS_DEF + CODE_BITS_DEF,
  parameter int DVS_BITS = SAMPLE_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire logic [DVD_BITS-1:0] dividend,
  input  wire logic [DVS_BITS-1:0] divisor,
  output logic                     done,
  output logic      [DVD_BITS-1:0] quotient
);

  localparam int CNT_BITS = $clog2(DVD_BITS + 1);

  logic                busy;
  logic [CNT_BITS-1:0] cnt;
  logic [DVD_BITS-1:0] quo;
  logic [DVS_BITS-1:0] rem;
  logic [DVS_BITS-1:0] dvs;
  logic [DVS_BITS:0]   rem_sh;
  logic                fit;

  assign rem_sh   = {rem, quo[DVD_BITS-1]};
  assign fit      = rem_sh >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_BITS'(DVD_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fit ? DVS_BITS'(rem_sh - {1'b0, dvs}) : rem_sh[DVS_BITS-1:0];
      quo <= {quo[DVD_BITS-2:0], fit};
    end
  end

endmodule

`default_nettype wire

[dv/testbench.sv]
// ------------------------------------------------------------------------
// interpolation level search core testbench
// drives start and sample words on the input stream and predicts every
// output word from a cycle-free copy of the search and monitor behavior;
// covers idle samples, equal bound samples, probe clamping, not-found
// exits, change restarts, register extremes, random plant-driven searches
// under three idling mixes and a long output hold-off
// ------------------------------------------------------------------------
`default_nettype none

module testbench;
  import ils_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CODE_W         = CODE_BITS_DEF;
  localparam int SAMPLE_W       = SAMPLE_BITS_DEF;
  localparam int IN_W           = ((SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_W          = ((2 * CODE_W + 7) / 8) * 8;
  localparam int SAMPLE_MAX     = (1 << SAMPLE_W) - 1;
  localparam int SETTLE_CYCLES  = 24;
  localparam int END_CYCLES     = 40;
  localparam int HOLD_CYCLES    = 160;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 520;
  localparam int MAX_PRINTS     = 30;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [1:0]        status;
    logic [CODE_W-1:0] found;
  } level_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [IN_W-1:0]           s_tdata = '0;
  logic [0:0]                s_tuser = REQ_START;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [OUT_W-1:0]          m_tdata;
  logic [1:0]                m_tuser;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_TARGET;
  logic [SAMPLE_W-1:0]       cfg_data = '0;

  // search model state
  phase_t              ph;
  logic [CODE_W-1:0]   lo_b, hi_b, probe, next_code;
  logic [SAMPLE_W-1:0] lo_s, hi_s, ref_s, tgt, tol;

  level_result_t pending_results[$];

  int err_count = 0;
  int words_in = 0;
  int words_out = 0;
  int n_starts = 0;
  int n_found = 0;
  int n_not_found = 0;
  int n_restarts = 0;
  int n_settings = 0;
  int send_idle_pct = 37;
  int recv_idle_pct = 50;
  int hold_gen = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_cycles = 0;
  int plant_base, plant_slope, plant_noise;

  interpolation_level_search_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic model_reset();
    tgt = SAMPLE_W'(TARGET_RESET);
    tol = SAMPLE_W'(TOL_RESET);
    ph = PH_IDLE;
    lo_b = '0;
    hi_b = '1;
    probe = '0;
    lo_s = '0;
    hi_s = '0;
    ref_s = '0;
    next_code = '0;
  endtask

  function automatic logic [CODE_W-1:0] interp_probe();
    longint lo, hi, num, den, q, pos;
    if (lo_s == hi_s) return lo_b;
    lo = longint'(lo_b);
    hi = longint'(hi_b);
    num = (longint'(tgt) - longint'(lo_s)) * (hi - lo);
    den = longint'(hi_s) - longint'(lo_s);
    q = num / den;
    // floor rather than truncate toward zero
    if ((num % den) != 0 && ((num < 0) != (den < 0))) q = q - 1;
    pos = lo + q;
    if (pos < lo) pos = lo;
    if (pos > hi) pos = hi;
    return pos[CODE_W-1:0];
  endfunction

  function automatic level_result_t predict_level(input logic req, input logic [SAMPLE_W-1:0] s);
    level_result_t r;
    logic [SAMPLE_W-1:0] gap;
    logic miss;
    r = '0;
    r.status = ST_SEARCH;
    miss = 1'b0;
    if (req == REQ_START) begin
      lo_b = '0;
      hi_b = '1;
      ph = PH_LOW;
      n_starts++;
    end else begin
      case (ph)
        PH_LOW: begin
          lo_s = s;
          ph = PH_HIGH;
          r.code = hi_b;
        end
        PH_HIGH: begin
          hi_s = s;
          probe = interp_probe();
          ph = PH_PROBE;
          r.code = probe;
        end
        PH_PROBE: begin
          gap = (s > tgt) ? s - tgt : tgt - s;
          if (gap <= tol) begin
            ref_s = s;
            ph = PH_MONITOR;
            r.code = probe;
            r.status = ST_FOUND;
            r.found = probe;
            n_found++;
          end else begin
            if (s < tgt) begin
              if (probe == '1) miss = 1'b1;
              else lo_b = probe + 1'b1;
            end else begin
              if (probe == '0) miss = 1'b1;
              else hi_b = probe - 1'b1;
            end
            if (miss || lo_b >= hi_b) begin
              ph = PH_IDLE;
              r.status = ST_IDLE;
              n_not_found++;
            end else begin
              ph = PH_LOW;
              r.code = lo_b;
            end
          end
        end
        PH_MONITOR: begin
          gap = (ref_s > s) ? ref_s - s : s - ref_s;
          if ({1'b0, gap} <= {tol, 1'b0}) begin
            r.code = probe;
            r.status = ST_FOUND;
            r.found = probe;
          end else begin
            ref_s = s;
            lo_b = '0;
            hi_b = '1;
            ph = PH_LOW;
            r.status = ST_RESTART;
            n_restarts++;
          end
        end
        default: begin
          ph = PH_IDLE;
          r.status = ST_IDLE;
        end
      endcase
    end
    next_code = r.code;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("mismatch %s: got %0d expected %0d at output word %0d", what, got, want,
               words_out);
  endtask

  task automatic check_word();
    level_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected word", m_tdata, 0);
    end else begin
      want = pending_results.pop_front();
      if (m_tdata[CODE_W-1:0] !== want.code)
        report_mismatch("apply_code", m_tdata[CODE_W-1:0], want.code);
      if (m_tuser !== want.status)
        report_mismatch("search_status", m_tuser, want.status);
      if (m_tdata[2*CODE_W-1:CODE_W] !== want.found)
        report_mismatch("found_code", m_tdata[2*CODE_W-1:CODE_W], want.found);
    end
    words_out++;
  endtask

  // output side: checks and ready generation, with long hold-offs on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) check_word();
      if (hold_gen != hold_seen) begin
        hold_seen = hold_gen;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_word(input logic req, input logic [SAMPLE_W-1:0] value);
    level_result_t r;
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= IN_W'(value);
    do @(posedge clk); while (!s_tready);
    r = predict_level(req, value);
    pending_results.push_back(r);
    words_in++;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_levels(input int target, input int tolerance);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_TARGET;
    cfg_data <= SAMPLE_W'(target);
    @(posedge clk);
    cfg_index <= REG_TOL;
    cfg_data <= SAMPLE_W'(tolerance);
    @(posedge clk);
    cfg_we <= 1'b0;
    tgt = SAMPLE_W'(target);
    tol = SAMPLE_W'(tolerance);
    n_settings++;
  endtask

  function automatic logic [SAMPLE_W-1:0] clamp_sample(input int v);
    if (v < 0) return '0;
    if (v > SAMPLE_MAX) return '1;
    return SAMPLE_W'(v);
  endfunction

  function automatic logic [SAMPLE_W-1:0] plant_sample(input int code);
    int v;
    v = plant_base + plant_slope * code;
    if (plant_noise > 0) v = v + int'($urandom_range(2 * plant_noise)) - plant_noise;
    return clamp_sample(v);
  endfunction

  // new attenuator curve that crosses the target somewhere in the code range
  task automatic pick_plant();
    int c0;
    plant_slope = int'($urandom_range(40)) - 20;
    c0 = $urandom_range(63);
    plant_base = int'(tgt) - plant_slope * c0;
    plant_noise = ($urandom_range(3) == 0) ? int'($urandom_range(4)) : 0;
  endtask

  function automatic logic [SAMPLE_W-1:0] near_reference();
    int span;
    span = 2 * int'(tol) + 2;
    return clamp_sample(int'(ref_s) + int'($urandom_range(2 * span)) - span);
  endfunction

  task automatic run_search_sequence(input int max_steps);
    int steps, pick;
    pick_plant();
    if ($urandom_range(19) == 0) send_word(REQ_SAMPLE, SAMPLE_W'($urandom));
    send_word(REQ_START, SAMPLE_W'($urandom));
    steps = 0;
    while (ph != PH_IDLE && steps < max_steps) begin
      pick = $urandom_range(99);
      if (pick < 3) send_word(REQ_START, SAMPLE_W'($urandom));
      else if (pick < 6) send_word(REQ_SAMPLE, SAMPLE_W'($urandom));
      else if (ph == PH_MONITOR) begin
        if ($urandom_range(3) == 0) send_word(REQ_SAMPLE, SAMPLE_W'($urandom));
        else send_word(REQ_SAMPLE, near_reference());
      end else begin
        send_word(REQ_SAMPLE, plant_sample(int'(next_code)));
      end
      steps++;
    end
  endtask

  task automatic pick_levels();
    int target, tolerance;
    case ($urandom_range(9))
      0:       target = 0;
      1:       target = SAMPLE_MAX;
      default: target = $urandom_range(SAMPLE_MAX);
    endcase
    case ($urandom_range(11))
      0:       tolerance = 0;
      1:       tolerance = SAMPLE_MAX;
      2:       tolerance = $urandom_range(SAMPLE_MAX);
      default: tolerance = $urandom_range(8);
    endcase
    set_levels(target, tolerance);
  endtask

  task automatic test_idle_samples();
    send_word(REQ_SAMPLE, '0);
    send_word(REQ_SAMPLE, '1);
  endtask

  task automatic test_equal_bounds_and_monitor();
    send_word(REQ_START, '0);
    send_word(REQ_SAMPLE, 10'd500);
    send_word(REQ_SAMPLE, 10'd500);
    send_word(REQ_SAMPLE, 10'd286);
    send_word(REQ_SAMPLE, 10'd290);
    // one count past twice the tolerance
    send_word(REQ_SAMPLE, 10'd291);
    // falling curve
    send_word(REQ_SAMPLE, 10'd1023);
    send_word(REQ_SAMPLE, 10'd0);
    send_word(REQ_SAMPLE, 10'd0);
  endtask

  task automatic test_probe_clamp();
    send_word(REQ_START, '1);
    send_word(REQ_SAMPLE, 10'd400);
    send_word(REQ_SAMPLE, 10'd1000);
    send_word(REQ_SAMPLE, 10'd1023);
    send_word(REQ_START, '0);
    send_word(REQ_SAMPLE, 10'd0);
    send_word(REQ_SAMPLE, 10'd100);
    send_word(REQ_SAMPLE, 10'd0);
  endtask

  task automatic test_bounds_meet_and_restart();
    send_word(REQ_START, '0);
    send_word(REQ_SAMPLE, 10'd0);
    send_word(REQ_SAMPLE, 10'd287);
    send_word(REQ_SAMPLE, 10'd0);
    send_word(REQ_SAMPLE, 10'd286);
    send_word(REQ_START, '0);
    send_word(REQ_SAMPLE, 10'd10);
    send_word(REQ_START, '0);
  endtask

  task automatic test_level_registers();
    set_levels(0, 0);
    run_search_sequence(12);
    set_levels(SAMPLE_MAX, SAMPLE_MAX);
    run_search_sequence(6);
    set_levels(SAMPLE_MAX, 0);
    run_search_sequence(12);
    set_levels(TARGET_RESET, TOL_RESET);
  endtask

  task automatic test_random_searches(input int send_pct, input int recv_pct);
    int goal;
    goal = words_in + RANDOM_ITEMS;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (words_in < goal) begin
      if ($urandom_range(7) == 0) pick_levels();
      run_search_sequence($urandom_range(30, 8));
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain_results();
    hold_gen++;
    run_search_sequence(12);
    // sender pause until every word is back
    drain_results();
    run_search_sequence(12);
  endtask

  initial begin
    model_reset();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_samples();
    test_equal_bounds_and_monitor();
    test_probe_clamp();
    test_bounds_meet_and_restart();
    test_level_registers();
    test_random_searches(37, 50);
    test_random_searches(50, 37);
    test_random_searches(0, 0);
    test_backpressure();
    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    $display("run covered %0d words in and %0d words out over %0d searches, %0d level settings",
             words_in, words_out, n_starts, n_settings);
    $display("outcomes: %0d found, %0d not found, %0d restarts on level change",
             n_found, n_not_found, n_restarts);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+sv
sv/ils_pkg.sv
sv/ils_div.sv
sv/interpolation_level_search_core.sv
dv/testbench.sv
